// File: sv/tlqe_pkg.sv
// Shared types and constants for the tree LCA query engine.
// Used by tlqe_seq and tree_lca_query_engine_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tlqe_pkg;

  localparam int NODE_W        = 10;
  localparam int HIT_W         = 16;
  localparam int NODE_SPAN     = 1 << NODE_W;
  localparam int NODES_DEFAULT = 1024;
  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_EDGE,
    S_RDCNT,
    S_WALK,
    S_LIFT_A,
    S_LIFT_B,
    S_JA,
    S_JB,
    S_HIT,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_a;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [HIT_W-1:0]  hit_total;
    logic [NODE_W-1:0] ancestor_node;
  } res_t;

endpackage

`default_nettype wire

// File: sv/tree_lca_query_engine_core.sv
// Top level of the tree LCA query engine: stream ports and result register.
// Depends on tlqe_pkg and tlqe_seq.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | contents
//  s_*      | in        | request: tuser = cmd, tdata = node_a, node_b
//  m_*      | out       | result: tdata = ancestor_node, hit_total; tuser = status
//
// After reset a clearing pass over min(NODES, 1024) entries runs; s_tready is low.
// A clear request runs the same pass again; add edge and read count go through
// S_EDGE or S_RDCNT before the result. A query walks node_a and then node_b to
// the root to find the depths da and db, lifts the deeper node, then steps both
// to the meeting point and updates its hit count; each step is one parent-link read.
// One request is in work at a time; the result waits in the output register while
// the next request is accepted.
module tree_lca_query_engine_core #(
  parameter int NODES = tlqe_pkg::NODES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // node_a [9:0], node_b [19:10], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // ancestor_node [9:0], hit_total [25:10], zero pad
  output logic [0:0]       m_tuser    // status [0]
);
  import tlqe_pkg::*;

  req_t req;
  res_t res;
  logic res_valid, res_ready;
  logic [NODE_W-1:0] out_anc;
  logic [HIT_W-1:0]  out_hits;
  logic              out_err;

  assign req.cmd    = cmd_t'(s_tuser);
  assign req.node_a = s_tdata[NODE_W-1:0];
  assign req.node_b = s_tdata[2*NODE_W-1:NODE_W];

  tlqe_seq #(
    .NODES(NODES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_tvalid),
    .req_ready(s_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_anc  <= res.ancestor_node;
      out_hits <= res.hit_total;
      out_err  <= res.status;
    end
  end

  assign m_tdata = {6'd0, out_hits, out_anc};
  assign m_tuser = out_err;

  // Every request keeps the engine busy in the cycle after it is accepted.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while engine stayed ready");

  // An error result carries no node and no count.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("error result with nonzero payload");

  // A result handed over by the sequencer shows up on the output.
  a_result_handoff: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("result lost between sequencer and output register");

endmodule

`default_nettype wire

// File: sv/tlqe_seq.sv
// Command sequencer for the LCA engine: parent-link and hit-count memories
// and the walk state machine that steps one pointer per cycle. Uses tlqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlqe_seq #(
  parameter int NODES = tlqe_pkg::NODES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tlqe_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output tlqe_pkg::res_t     res
);
  import tlqe_pkg::*;

  localparam int DEPTH = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(NODES + 1);

  // Link entry: has-parent flag above the parent index.
  logic [AW:0]      link_mem [DEPTH];
  logic [HIT_W-1:0] hits_mem [DEPTH];

  state_t state, state_next;
  logic [AW-1:0] na, na_next, nb, nb_next, ra, ra_next, ptr, ptr_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [SW-1:0] steps, steps_next, da, da_next, db, db_next;
  logic          walk_b, walk_b_next;
  logic [NODE_W-1:0] res_anc, res_anc_next;
  logic [HIT_W-1:0]  res_hits, res_hits_next;
  logic              res_err, res_err_next;

  logic [AW:0]      link_q;
  logic [HIT_W-1:0] hits_q;
  logic             link_we, hit_we;
  logic [AW-1:0]    link_waddr, hit_waddr, hits_raddr;
  logic [AW:0]      link_wdata;
  logic [HIT_W-1:0] hit_wdata, hit_inc;
  logic             a_ok, b_ok, link_valid;
  logic [AW-1:0]    link_parent;

  assign link_valid  = link_q[AW];
  assign link_parent = link_q[AW-1:0];
  assign a_ok = 32'(req.node_a) < 32'(NODES);
  assign b_ok = 32'(req.node_b) < 32'(NODES);
  assign hit_inc = (hits_q == HIT_MAX) ? hits_q : hits_q + HIT_W'(1);
  assign hits_raddr = (state == S_IDLE) ? req.node_a[AW-1:0] : na;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hits_mem[hit_waddr] <= hit_wdata;
    end
    hits_q <= hits_mem[hits_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
    na       <= na_next;
    nb       <= nb_next;
    ra       <= ra_next;
    ptr      <= ptr_next;
    steps    <= steps_next;
    da       <= da_next;
    db       <= db_next;
    walk_b   <= walk_b_next;
    res_anc  <= res_anc_next;
    res_hits <= res_hits_next;
    res_err  <= res_err_next;
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    na_next       = na;
    nb_next       = nb;
    ra_next       = ra;
    ptr_next      = ptr;
    steps_next    = steps;
    da_next       = da;
    db_next       = db;
    walk_b_next   = walk_b;
    res_anc_next  = res_anc;
    res_hits_next = res_hits;
    res_err_next  = res_err;
    link_we       = 1'b0;
    link_waddr    = clr_addr;
    link_wdata    = '0;
    hit_we        = 1'b0;
    hit_waddr     = clr_addr;
    hit_wdata     = '0;
    req_ready     = 1'b0;
    res_valid     = 1'b0;

    case (state)
      S_INIT, S_CLR: begin
        link_we       = 1'b1;
        hit_we        = 1'b1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          clr_addr_next = '0;
          state_next    = (state == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          na_next       = req.node_a[AW-1:0];
          nb_next       = req.node_b[AW-1:0];
          res_anc_next  = '0;
          res_hits_next = '0;
          res_err_next  = 1'b0;
          case (req.cmd)
            CMD_CLEAR: begin
              clr_addr_next = '0;
              state_next    = S_CLR;
            end
            CMD_READ: begin
              if (a_ok) begin
                state_next = S_RDCNT;
              end else begin
                res_err_next = 1'b1;
                state_next   = S_DONE;
              end
            end
            CMD_EDGE: begin
              if (a_ok && b_ok) begin
                state_next = S_EDGE;
              end else begin
                res_err_next = 1'b1;
                state_next   = S_DONE;
              end
            end
            CMD_QUERY: begin
              if (a_ok && b_ok) begin
                ptr_next    = req.node_a[AW-1:0];
                steps_next  = '0;
                walk_b_next = 1'b0;
                state_next  = S_WALK;
              end else begin
                res_err_next = 1'b1;
                state_next   = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_EDGE: begin
        link_we    = 1'b1;
        link_waddr = nb;
        link_wdata = {1'b1, na};
        state_next = S_DONE;
      end
      S_RDCNT: begin
        res_hits_next = hits_q;
        state_next    = S_DONE;
      end
      S_WALK: begin
        // link_q always holds the entry at ptr, so one parent step per cycle.
        if (!link_valid) begin
          if (!walk_b) begin
            ra_next     = ptr;
            da_next     = steps;
            walk_b_next = 1'b1;
            ptr_next    = nb;
            steps_next  = '0;
          end else begin
            db_next = steps;
            if (ptr != ra) begin
              res_err_next = 1'b1;
              state_next   = S_DONE;
            end else begin
              ptr_next   = na;
              state_next = S_LIFT_A;
            end
          end
        end else if (steps == SW'(NODES)) begin
          // A walk this long can only come from a cycle in the links.
          res_err_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          ptr_next   = link_parent;
          steps_next = steps + SW'(1);
        end
      end
      S_LIFT_A: begin
        if (da > db) begin
          na_next  = link_parent;
          ptr_next = link_parent;
          da_next  = da - SW'(1);
        end else begin
          ptr_next   = nb;
          state_next = S_LIFT_B;
        end
      end
      S_LIFT_B: begin
        if (db > da) begin
          nb_next  = link_parent;
          ptr_next = link_parent;
          db_next  = db - SW'(1);
        end else begin
          ptr_next   = na;
          state_next = S_JA;
        end
      end
      S_JA: begin
        if (na == nb || da == '0) begin
          state_next = S_HIT;
        end else begin
          na_next    = link_parent;
          ptr_next   = nb;
          state_next = S_JB;
        end
      end
      S_JB: begin
        nb_next    = link_parent;
        da_next    = da - SW'(1);
        ptr_next   = na;
        state_next = S_JA;
      end
      S_HIT: begin
        hit_we        = 1'b1;
        hit_waddr     = na;
        hit_wdata     = hit_inc;
        res_anc_next  = NODE_W'(na);
        res_hits_next = hit_inc;
        state_next    = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.ancestor_node = res_anc;
  assign res.hit_total     = res_hits;
  assign res.status        = res_err;

endmodule

`default_nettype wire

// File: sim/tree_lca_query_engine_core_tb.sv
// Self-checking testbench for tree_lca_query_engine_core: directed requests from a table
// and random tree building, checked against a local LCA model.
// Depends on tlqe_pkg and the engine RTL.
`timescale 1ns / 1ps

module tree_lca_query_engine_core_tb;
  import tlqe_pkg::*;

  localparam int NODE_COUNT  = NODES_DEFAULT;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    cmd_t              cmd;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;
    res_t              want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_CLEAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  // Local copy of the forest and the hit histogram.
  logic [NODE_W-1:0] link_of [NODE_COUNT];
  bit                linked  [NODE_COUNT];
  logic [HIT_W-1:0]  hits_of [NODE_COUNT];

  res_t      pending_res[$];
  plan_row_t plan[$];
  res_t      head_res;
  int        mismatches = 0;
  int        result_count = 0;
  int        req_count = 0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;

  tree_lca_query_engine_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Walks parent links to the root; fails when the walk runs past NODE_COUNT steps.
  function automatic bit climb(input logic [NODE_W-1:0] start, output int depth,
                               output logic [NODE_W-1:0] root);
    logic [NODE_W-1:0] n;
    int steps;
    n = start;
    steps = 0;
    while (linked[n]) begin
      if (steps >= NODE_COUNT) return 1'b0;
      n = link_of[n];
      steps++;
    end
    depth = steps;
    root = n;
    return 1'b1;
  endfunction

  function automatic res_t lca_predict(cmd_t c, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    res_t r;
    int da, db;
    logic [NODE_W-1:0] ra, rb;
    r = '0;
    case (c)
      CMD_CLEAR: begin
        for (int i = 0; i < NODE_COUNT; i++) begin
          linked[i] = 1'b0;
          hits_of[i] = '0;
        end
      end
      CMD_EDGE: begin
        link_of[b] = a;
        linked[b] = 1'b1;
      end
      CMD_READ: r.hit_total = hits_of[a];
      default: begin
        if (!climb(a, da, ra) || !climb(b, db, rb) || ra != rb) begin
          r.status = 1'b1;
        end else begin
          while (da > db) begin
            a = link_of[a];
            da--;
          end
          while (db > da) begin
            b = link_of[b];
            db--;
          end
          while (a != b && da > 0) begin
            a = link_of[a];
            b = link_of[b];
            da--;
          end
          if (hits_of[a] != HIT_MAX) hits_of[a]++;
          r.ancestor_node = a;
          r.hit_total = hits_of[a];
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, int idx, logic [31:0] got, logic [31:0] want);
    $display("mismatch in result %0d: %s is %0d, expected %0d", idx, field, got, want);
    mismatches++;
  endtask

  // Drives one request and records its expected result once it is accepted.
  task automatic send_req(cmd_t c, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                          bit typed = 1'b0, res_t want = '0);
    res_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, b, a};
    s_tuser  <= c;
    do @(posedge clk); while (!s_tready);
    r = lca_predict(c, a, b);
    pending_res = {pending_res, (typed ? want : r)};
    req_count++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
  endtask

  task automatic add_row(cmd_t c, int a, int b, bit typed = 1'b0,
                         int anc = 0, int hit = 0, int st = 0);
    plan_row_t pr;
    pr.cmd = c;
    pr.a = a[NODE_W-1:0];
    pr.b = b[NODE_W-1:0];
    pr.typed = typed;
    pr.want.ancestor_node = anc[NODE_W-1:0];
    pr.want.hit_total = hit[HIT_W-1:0];
    pr.want.status = st[0];
    plan = {plan, pr};
  endtask

  // Mostly small well-formed trees with queries over their nodes, a few long chains,
  // rare clears and some unstructured requests that may build cycles.
  task automatic random_mix(int total, int calm_after);
    logic [NODE_W-1:0] pool [64];
    logic [NODE_W-1:0] x, y;
    int start, pick, k, clears;
    start = req_count;
    clears = 0;
    while (req_count - start < total) begin
      if (req_count - start >= calm_after) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3 && clears < 4) begin
        clears++;
        send_req(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
      end else if (pick < 6) begin
        k = $urandom_range(20, 60);
        pool[0] = NODE_W'($urandom);
        for (int i = 1; i < k; i++) begin
          pool[i] = pool[i-1] + 1'b1;
          send_req(CMD_EDGE, pool[i-1], pool[i]);
        end
        repeat (4) begin
          x = pool[$urandom_range(0, k - 1)];
          y = pool[$urandom_range(0, k - 1)];
          send_req(CMD_QUERY, x, y);
        end
        send_req(CMD_READ, pool[0], NODE_W'($urandom));
      end else if (pick < 8) begin
        wait_drained();
      end else if (pick < 72) begin
        k = $urandom_range(2, 12);
        pool[0] = NODE_W'($urandom);
        for (int i = 1; i < k; i++) begin
          pool[i] = NODE_W'($urandom);
          send_req(CMD_EDGE, pool[$urandom_range(0, i - 1)], pool[i]);
        end
        repeat ($urandom_range(2, 8)) begin
          x = pool[$urandom_range(0, k - 1)];
          y = pool[$urandom_range(0, k - 1)];
          send_req(CMD_QUERY, x, y);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_req(CMD_READ, pool[$urandom_range(0, k - 1)], NODE_W'($urandom));
        end
      end else begin
        send_req(cmd_t'($urandom_range(1, 3)), NODE_W'($urandom), NODE_W'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("result with no request pending", result_count, m_tdata, 0);
      end else begin
        head_res = pending_res.pop_front();
        if (m_tdata[9:0] !== head_res.ancestor_node)
          report_mismatch("ancestor_node", result_count, 32'(m_tdata[9:0]),
                          32'(head_res.ancestor_node));
        if (m_tdata[25:10] !== head_res.hit_total)
          report_mismatch("hit_total", result_count, 32'(m_tdata[25:10]),
                          32'(head_res.hit_total));
        if (m_tuser[0] !== head_res.status)
          report_mismatch("status", result_count, 32'(m_tuser[0]), 32'(head_res.status));
      end
      result_count++;
    end
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
    m_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NODE_COUNT; i++) begin
      link_of[i] = '0;
      linked[i] = 1'b0;
      hits_of[i] = '0;
    end

    add_row(CMD_READ, 0, 0, 1'b1, 0, 0, 0);
    add_row(CMD_READ, 1023, 0, 1'b1, 0, 0, 0);
    add_row(CMD_QUERY, 0, 1023, 1'b1, 0, 0, 1);     // two separate roots
    add_row(CMD_EDGE, 0, 1, 1'b1, 0, 0, 0);
    add_row(CMD_EDGE, 0, 2, 1'b1, 0, 0, 0);
    add_row(CMD_EDGE, 1, 3, 1'b1, 0, 0, 0);
    add_row(CMD_EDGE, 2, 1023, 1'b1, 0, 0, 0);
    add_row(CMD_QUERY, 3, 1023);
    add_row(CMD_QUERY, 3, 3);
    add_row(CMD_QUERY, 1, 3);
    add_row(CMD_QUERY, 1023, 0);
    add_row(CMD_READ, 0, 1023);
    add_row(CMD_EDGE, 3, 1, 1'b1, 0, 0, 0);         // closes the loop 1 -> 3 -> 1
    add_row(CMD_QUERY, 3, 2, 1'b1, 0, 0, 1);
    add_row(CMD_QUERY, 2, 3, 1'b1, 0, 0, 1);
    add_row(CMD_EDGE, 0, 1, 1'b1, 0, 0, 0);         // relinking node 1 breaks the loop
    add_row(CMD_QUERY, 3, 1023);
    add_row(CMD_EDGE, 682, 341, 1'b1, 0, 0, 0);
    add_row(CMD_QUERY, 341, 341);
    add_row(CMD_CLEAR, 1023, 1023, 1'b1, 0, 0, 0);
    add_row(CMD_READ, 0, 0, 1'b1, 0, 0, 0);
    add_row(CMD_QUERY, 3, 1023, 1'b1, 0, 0, 1);     // stale links must not count
    add_row(CMD_QUERY, 1023, 1023, 1'b1, 1023, 1, 0);
    add_row(CMD_EDGE, 1023, 0, 1'b1, 0, 0, 0);
    add_row(CMD_QUERY, 0, 1023);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_req(plan[i].cmd, plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
    wait_drained();

    random_mix(265, 225);

    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
